FILE: rtl/sorted_key_bucket_index_builder_top_assert.svh
// assertion macros shared by the index builder modules
// expects clk and rst in the scope where a macro is used
`ifndef SORTED_KEY_BUCKET_INDEX_BUILDER_TOP_ASSERT_SVH
`define SORTED_KEY_BUCKET_INDEX_BUILDER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SKBIB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SKBIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/skbib_pkg.sv
// shared types and constants of the sorted key bucket index builder
// no dependencies
package skbib_pkg;

  localparam int CFG_W      = 6;
  localparam int KEY_PORT_W = 32;
  localparam int ADDR_W     = 33;
  localparam int LOC_W      = 32;

  localparam logic [CFG_W-1:0] MAX_GROUP_SIZE_RESET = 6'd32;
  localparam logic [CFG_W-1:0] KEY_BITS_RESET       = 6'd26;

  // clears bit 0 of a position before the strand goes in
  localparam logic [LOC_W-1:0] PACK_MASK = 32'hFFFF_FFFE;

  typedef enum logic [0:0] {
    REG_MAX_GROUP_SIZE = 1'b0,
    REG_KEY_BITS       = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH_RD,
    ST_FLUSH_WR,
    ST_FILL,
    ST_ERROR
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_WRITE,
    EMIT_FILL,
    EMIT_ERROR
  } emit_t;

  typedef struct packed {
    logic  latch_item;
    logic  clear_idx;
    logic  rd_en;
    emit_t emit;
    logic  push_same;
    logic  new_group;
    logic  stream_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic is_end;
    logic is_err;
    logic same_key;
    logic flush_needed;
    logic idx_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/skbib_ctrl.sv
// controller state machine of the index builder
// depends on skbib_pkg and the assertion macro header
`include "sorted_key_bucket_index_builder_top_assert.svh"

module skbib_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  skbib_pkg::dp_status_t  status,
  output skbib_pkg::dp_cmd_t     cmd
);
  import skbib_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_err) begin
          state_next = ST_ERROR;
        end else if (!status.is_end && status.same_key) begin
          state_next = ST_IDLE;
        end else if (status.flush_needed) begin
          state_next = ST_FLUSH_RD;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_FLUSH_RD: begin
        state_next = ST_FLUSH_WR;
      end
      ST_FLUSH_WR: begin
        if (status.out_free) begin
          state_next = status.idx_last ? ST_FILL : ST_FLUSH_RD;
        end
      end
      ST_FILL, ST_ERROR: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.emit = EMIT_NONE;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
      end
      ST_DECODE: begin
        cmd.clear_idx = 1'b1;
        cmd.push_same = !status.is_err && !status.is_end && status.same_key;
      end
      ST_FLUSH_RD: begin
        cmd.rd_en = 1'b1;
      end
      ST_FLUSH_WR: begin
        if (status.out_free) begin
          cmd.emit = EMIT_WRITE;
        end
      end
      ST_FILL: begin
        if (status.out_free) begin
          cmd.emit         = EMIT_FILL;
          cmd.stream_clear = status.is_end;
          cmd.new_group    = !status.is_end;
        end
      end
      ST_ERROR: begin
        if (status.out_free) begin
          cmd.emit = EMIT_ERROR;
        end
      end
      default: begin
        cmd.emit = EMIT_NONE;
      end
    endcase
  end

  `SKBIB_ASSERT_NOW(a_emit_needs_room, cmd.emit != EMIT_NONE, status.out_free,
    "result emitted while output register is occupied")
  `SKBIB_ASSERT_NEXT(a_read_then_write, state == ST_FLUSH_RD, state == ST_FLUSH_WR,
    "buffer read not followed by its write result")
  `SKBIB_ASSERT_NEXT(a_latch_then_decode, cmd.latch_item, state == ST_DECODE,
    "accepted item not decoded next cycle")

endmodule

FILE: rtl/skbib_dp.sv
// datapath of the index builder: config, stream state, group buffer, output register
// depends on skbib_pkg and the assertion macro header
`include "sorted_key_bucket_index_builder_top_assert.svh"

module skbib_dp #(
  parameter int MAX_GROUP = 32,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [skbib_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                cmd_in,
  input  logic [skbib_pkg::KEY_PORT_W-1:0]    key,
  input  logic [skbib_pkg::LOC_W-1:0]         position,
  input  logic                                strand,
  input  skbib_pkg::dp_cmd_t                  cmd,
  output skbib_pkg::dp_status_t               status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          kind,
  output logic [skbib_pkg::ADDR_W-1:0]        start_addr,
  output logic [skbib_pkg::ADDR_W-1:0]        end_addr,
  output logic [skbib_pkg::LOC_W-1:0]         value,
  output logic                                last
);
  import skbib_pkg::*;

  localparam int GW = $clog2(MAX_GROUP + 2);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int LW = (GW > CFG_W) ? GW : CFG_W;

  // configuration
  logic [CFG_W-1:0] cfg_max;
  logic [CFG_W-1:0] cfg_kbits;

  // held item
  logic                  item_cmd;
  logic [KEY_PORT_W-1:0] item_key;
  logic [LOC_W-1:0]      item_pos;
  logic                  item_strand;

  // stream state
  logic [KEY_WIDTH-1:0] cur_key;
  logic                 started;
  logic [GW-1:0]        gs;
  logic [GW-1:0]        gs_next;
  logic [LOC_W-1:0]     loc_count;
  logic [GW-1:0]        idx;

  // group buffer
  logic [LOC_W-1:0] mem [MAX_GROUP];
  logic [LOC_W-1:0] rd_data;
  logic             mem_we;
  logic [GW-1:0]    base;

  logic [CFG_W-1:0]  kb;
  logic [ADDR_W-1:0] tsize;
  logic [GW-1:0]     eff;
  logic [GW-1:0]     idx_inc;
  logic [LOC_W-1:0]  packed_loc;
  logic              push_en;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_max   <= MAX_GROUP_SIZE_RESET;
      cfg_kbits <= KEY_BITS_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MAX_GROUP_SIZE: cfg_max   <= cfg_data;
        REG_KEY_BITS:       cfg_kbits <= cfg_data;
        default:            cfg_max   <= cfg_max;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_cmd    <= cmd_in;
      item_key    <= key;
      item_pos    <= position;
      item_strand <= strand;
    end
  end

  always_comb begin
    kb = (cfg_kbits > CFG_W'(KEY_WIDTH)) ? CFG_W'(KEY_WIDTH) : cfg_kbits;
    tsize = ADDR_W'(1) << kb;
    eff = (LW'(cfg_max) > LW'(MAX_GROUP)) ? GW'(MAX_GROUP) : GW'(cfg_max);
    idx_inc = idx + GW'(1);
    packed_loc = (item_pos & PACK_MASK) | LOC_W'(item_strand);
    out_free = !out_valid || out_ready;

    status.is_end       = item_cmd;
    status.is_err       = !item_cmd && (({1'b0, item_key} >= tsize) ||
                          (started && item_key < KEY_PORT_W'(cur_key)));
    status.same_key     = started && (item_key == KEY_PORT_W'(cur_key));
    status.flush_needed = started && (gs != '0) && (gs <= eff);
    status.idx_last     = (idx_inc == gs);
    status.out_free     = out_free;
  end

  // push a packed location into the open group or mark it too large; clear at end
  always_comb begin
    push_en = cmd.push_same || cmd.new_group;
    base    = cmd.new_group ? '0 : gs;
    mem_we  = push_en && (base < eff);
    gs_next = gs;
    if (cmd.stream_clear) begin
      gs_next = '0;
    end else if (push_en) begin
      gs_next = (base < eff) ? base + GW'(1) : GW'(MAX_GROUP + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[base[AW-1:0]] <= packed_loc;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_key   <= '0;
      started   <= 1'b0;
      gs        <= '0;
      loc_count <= '0;
      idx       <= '0;
    end else begin
      gs <= gs_next;
      if (cmd.stream_clear) begin
        cur_key   <= '0;
        started   <= 1'b0;
        loc_count <= '0;
      end else if (cmd.new_group) begin
        cur_key <= item_key[KEY_WIDTH-1:0];
        started <= 1'b1;
      end
      if (cmd.clear_idx) begin
        idx <= '0;
      end else if (cmd.emit == EMIT_WRITE) begin
        idx       <= idx_inc;
        loc_count <= loc_count + LOC_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_WRITE: begin
        kind       <= KIND_WRITE;
        start_addr <= {1'b0, loc_count};
        end_addr   <= '0;
        value      <= rd_data;
        last       <= 1'b0;
      end
      EMIT_FILL: begin
        kind       <= KIND_FILL;
        start_addr <= ADDR_W'(cur_key);
        end_addr   <= item_cmd ? tsize : {1'b0, item_key};
        value      <= loc_count;
        last       <= 1'b1;
      end
      EMIT_ERROR: begin
        kind       <= KIND_ERROR;
        start_addr <= {1'b0, item_key};
        end_addr   <= '0;
        value      <= '0;
        last       <= 1'b1;
      end
      default: begin
        kind <= kind;
      end
    endcase
  end

  `SKBIB_ASSERT_NOW(a_gs_range, 1'b1, gs <= GW'(MAX_GROUP + 1),
    "group size beyond saturation value")
  `SKBIB_ASSERT_NOW(a_write_in_group, cmd.emit == EMIT_WRITE, (gs <= eff) && (idx < gs),
    "location write outside a kept group")
  `SKBIB_ASSERT_NEXT(a_clear_resets, cmd.stream_clear,
    (loc_count == '0) && !started && (gs == '0),
    "stream state not cleared after end item")

endmodule

FILE: rtl/sorted_key_bucket_index_builder_top.sv
// top level of the sorted key bucket index builder
// depends on skbib_pkg, skbib_ctrl and skbib_dp
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   input    | in_valid / in_ready    | cmd, key, position, strand
//   output   | out_valid / out_ready  | kind, start_addr, end_addr, value, last
//   config   | cfg_we                 | cfg_index, cfg_data
//
// a tuple with the current key: accept, then decode and push
// a key change or end item: decode, read and write each kept tuple, then fill;
//   the group buffer has one read port and each location write needs a read
// errors and groups without writes: accept, decode, then one result
// rst is synchronous; it restores config defaults and an empty stream
// a stalled output only holds the block when a new result must be loaded

module sorted_key_bucket_index_builder_top #(
  parameter int MAX_GROUP = 32,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [skbib_pkg::CFG_W-1:0]         cfg_data,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [skbib_pkg::KEY_PORT_W-1:0]    key,
  input  logic [skbib_pkg::LOC_W-1:0]         position,
  input  logic                                strand,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          kind,
  output logic [skbib_pkg::ADDR_W-1:0]        start_addr,
  output logic [skbib_pkg::ADDR_W-1:0]        end_addr,
  output logic [skbib_pkg::LOC_W-1:0]         value,
  output logic                                last
);
  import skbib_pkg::*;

  // commands from the controller, status back from the datapath
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer: decode, buffer reads for the flush, fill and error results
  skbib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  // stream state, group buffer and the output register
  skbib_dp #(
    .MAX_GROUP (MAX_GROUP),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_in     (cmd),
    .key        (key),
    .position   (position),
    .strand     (strand),
    .cmd        (dp_cmd),
    .status     (dp_status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .start_addr (start_addr),
    .end_addr   (end_addr),
    .value      (value),
    .last       (last)
  );

endmodule
